// ===== sv/assert_macros.svh =====
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the block clock, off during reset
`define KPTT_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define KPTT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/kptt_pkg.sv =====
`timescale 1ns / 1ps
package kptt_pkg;

   localparam logic [2:0] ACT_SCHEDULE       = 3'd0;
   localparam logic [2:0] ACT_UNSCHED_KEY    = 3'd1;
   localparam logic [2:0] ACT_UNSCHED_TARGET = 3'd2;
   localparam logic [2:0] ACT_TICK           = 3'd3;
   localparam logic [2:0] ACT_SET_STATE      = 3'd4;

   localparam logic [1:0] KIND_FIRE = 2'd0;
   localparam logic [1:0] KIND_ACK  = 2'd1;
   localparam logic [1:0] KIND_DONE = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_IGNORED = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   // operations broadcast to the cell row
   localparam logic [2:0] OP_HOLD        = 3'd0;
   localparam logic [2:0] OP_DROP_KEY    = 3'd1;
   localparam logic [2:0] OP_DROP_TARGET = 3'd2;
   localparam logic [2:0] OP_FLAGS       = 3'd3;
   localparam logic [2:0] OP_COMPACT     = 3'd4;
   localparam logic [2:0] OP_INSERT      = 3'd5;
   localparam logic [2:0] OP_EVAL        = 3'd6;
   localparam logic [2:0] OP_CLEAN       = 3'd7;

   // index into the per-slot time vector
   localparam int TM_INTERVAL = 0;
   localparam int TM_DELAY    = 1;
   localparam int TM_ELAPSED  = 2;

   localparam logic [16:0]        FIRE_COUNT_MAX = 17'h1FFFF;
   localparam logic signed [16:0] REPEAT_FOREVER = -17'sd1;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] target;
      logic [7:0] key;
      logic       run;
      logic       pause;
   } cell_ctl_type;

   typedef struct packed {
      logic               valid;
      logic [7:0]         target;
      logic [7:0]         key;
      logic signed [16:0] rpt;
      logic signed [15:0] prio;
      logic [31:0]        seq_num;
      logic [16:0]        fire_count;
      logic               run;
      logic               pause;
   } slot_info_type;

   // target id reduced by the flag table size, restoring style, eight steps
   function automatic logic [11:0] kptt_mod(input logic [7:0] v, input int unsigned m);
      logic [19:0] r;
      logic [19:0] d;
      r = 20'(v);
      for (int k = 7; k >= 0; k--) begin
         d = 20'(m) << k;
         if (r >= d) begin
            r = r - d;
         end
      end
      return r[11:0];
   endfunction

endpackage

// ===== sv/kptt_cell.sv =====
`timescale 1ns / 1ps
module kptt_cell #(
   parameter int TARGET_COUNT = 256,
   parameter int TIME_BITS    = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  kptt_pkg::cell_ctl_type        ctl,
   input  logic [TIME_BITS-1:0]          dt,
   input  kptt_pkg::slot_info_type       new_info,
   input  logic [2:0][TIME_BITS-1:0]     new_time,
   input  kptt_pkg::slot_info_type       prev_info,
   input  logic [2:0][TIME_BITS-1:0]     prev_time,
   input  kptt_pkg::slot_info_type       next_info,
   input  logic [2:0][TIME_BITS-1:0]     next_time,
   input  logic                          hole_in,
   input  logic                          ins_in,
   output kptt_pkg::slot_info_type       info_q,
   output logic [2:0][TIME_BITS-1:0]     time_q,
   output logic                          hole_out,
   output logic                          ins_out,
   output logic                          need,
   output logic                          match,
   output logic                          fire,
   output logic                          rm
);

   kptt_pkg::slot_info_type   info_ff, info_in;
   logic [2:0][TIME_BITS-1:0] time_ff, time_in;
   logic                      fire_ff, fire_in;
   logic                      rm_ff, rm_in;
   logic [11:0]               own_idx, bc_idx;
   logic                      earlier;

   assign own_idx = kptt_pkg::kptt_mod(info_ff.target, TARGET_COUNT);
   assign bc_idx  = kptt_pkg::kptt_mod(ctl.target, TARGET_COUNT);
   assign match   = info_ff.valid && info_ff.target == ctl.target && info_ff.key == ctl.key;
   assign earlier = (new_info.prio < info_ff.prio) ||
                    (new_info.prio == info_ff.prio && new_info.seq_num < info_ff.seq_num);
   assign hole_out = hole_in || !info_ff.valid;
   assign ins_out  = !info_ff.valid || earlier;
   assign need     = info_ff.valid && hole_in;

   always_comb begin
      logic                 fire_now;
      logic                 drop_now;
      logic [TIME_BITS:0]   sum;
      logic [TIME_BITS-1:0] el;
      logic [16:0]          cnt_n;
      fire_now = 1'b0;
      drop_now = 1'b0;
      sum      = '0;
      el       = '0;
      cnt_n    = info_ff.fire_count;
      info_in  = info_ff;
      time_in  = time_ff;
      fire_in  = fire_ff;
      rm_in    = rm_ff;
      case (ctl.op)
         kptt_pkg::OP_DROP_KEY: begin
            if (match) begin
               info_in.valid = 1'b0;
            end
         end
         kptt_pkg::OP_DROP_TARGET: begin
            if (info_ff.valid && info_ff.target == ctl.target) begin
               info_in.valid = 1'b0;
            end
         end
         kptt_pkg::OP_FLAGS: begin
            if (own_idx == bc_idx) begin
               info_in.run   = ctl.run;
               info_in.pause = ctl.pause;
            end
         end
         kptt_pkg::OP_COMPACT: begin
            // everything behind the first hole moves up one place
            if (hole_out) begin
               info_in = next_info;
               time_in = next_time;
            end
         end
         kptt_pkg::OP_INSERT: begin
            if (ins_in) begin
               info_in = prev_info;
               time_in = prev_time;
            end else if (ins_out) begin
               info_in = new_info;
               time_in = new_time;
            end
         end
         kptt_pkg::OP_EVAL: begin
            if (info_ff.valid && info_ff.run && !info_ff.pause) begin
               if (time_ff[kptt_pkg::TM_DELAY] != '0) begin
                  if (dt >= time_ff[kptt_pkg::TM_DELAY]) begin
                     time_in[kptt_pkg::TM_DELAY]   = '0;
                     time_in[kptt_pkg::TM_ELAPSED] = '0;
                     fire_now = 1'b1;
                  end else begin
                     time_in[kptt_pkg::TM_DELAY] = time_ff[kptt_pkg::TM_DELAY] - dt;
                  end
               end else if (time_ff[kptt_pkg::TM_INTERVAL] == '0) begin
                  fire_now = 1'b1;
               end else begin
                  sum = {1'b0, time_ff[kptt_pkg::TM_ELAPSED]} + {1'b0, dt};
                  el  = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
                  if (el >= time_ff[kptt_pkg::TM_INTERVAL]) begin
                     el = el - time_ff[kptt_pkg::TM_INTERVAL];
                     fire_now = 1'b1;
                  end
                  time_in[kptt_pkg::TM_ELAPSED] = el;
               end
               if (fire_now) begin
                  if (info_ff.fire_count != kptt_pkg::FIRE_COUNT_MAX) begin
                     cnt_n = info_ff.fire_count + 17'd1;
                  end
                  info_in.fire_count = cnt_n;
                  // repeat is never below -1, so a plain compare does
                  drop_now = info_ff.rpt != kptt_pkg::REPEAT_FOREVER &&
                             cnt_n > $unsigned(info_ff.rpt);
               end
            end
            fire_in = fire_now;
            rm_in   = info_ff.valid && (drop_now || !info_ff.run);
         end
         kptt_pkg::OP_CLEAN: begin
            if (rm_ff) begin
               info_in.valid = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      time_ff <= time_in;
      fire_ff <= fire_in;
      rm_ff   <= rm_in;
      if (reset) begin
         info_ff <= '0;
      end else begin
         info_ff <= info_in;
      end
   end

   assign info_q = info_ff;
   assign time_q = time_ff;
   assign fire   = fire_ff;
   assign rm     = rm_ff;

endmodule

// ===== sv/keyed_periodic_timer_table_top.sv =====
`timescale 1ns / 1ps
// channel   ports                      handshake
// request   start, busy, req_*         word taken when start is high and busy low
// response  rsp_valid, rsp_*           one word per strobe, no back-pressure
//
// busy is high through every step of a command: an ignored command, a full table or
// a flag write just acks, an unschedule compacts and a schedule compacts, then
// inserts, with at most one compaction pass per removed slot; a tick walks the cell
// row one slot a cycle, then cleans and compacts. each word leaves in the cycle after
// it is formed. after reset the flag table is swept one entry a cycle with busy high.
// the receiver cannot stall; every result is a one-cycle strobe.
module keyed_periodic_timer_table_top #(
   parameter int MAX_SLOTS    = 16,
   parameter int TARGET_COUNT = 256,
   parameter int TIME_BITS    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_action,
   input  logic [7:0]  req_target_id,
   input  logic [7:0]  req_key_id,
   input  logic [31:0] req_interval,
   input  logic [31:0] req_delay,
   input  logic signed [16:0] req_repeat_req,
   input  logic signed [15:0] req_priority_req,
   input  logic [31:0] req_dt,
   input  logic        req_running,
   input  logic        req_paused,
   output logic        rsp_valid,
   output logic [1:0]  rsp_kind,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_fired_target,
   output logic [7:0]  rsp_fired_key,
   output logic [31:0] rsp_fired_dt,
   output logic [4:0]  rsp_scheduled_count,
   output logic        rsp_last
);

`include "assert_macros.svh"

   localparam int TIW = $clog2(TARGET_COUNT);
   localparam int WW  = $clog2(MAX_SLOTS);
   localparam int CW  = $clog2(MAX_SLOTS + 1);
   localparam logic [TIME_BITS-1:0] TMAX = '1;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_CLR     = 4'd1;
   localparam logic [3:0] ST_CMD     = 4'd2;
   localparam logic [3:0] ST_COMPACT = 4'd3;
   localparam logic [3:0] ST_INSERT  = 4'd4;
   localparam logic [3:0] ST_ACK     = 4'd5;
   localparam logic [3:0] ST_CNT     = 4'd6;
   localparam logic [3:0] ST_WALK    = 4'd7;
   localparam logic [3:0] ST_CLEAN   = 4'd8;
   localparam logic [3:0] ST_DONE    = 4'd9;

   localparam logic [1:0] AFT_ACK    = 2'd0;
   localparam logic [1:0] AFT_INSERT = 2'd1;
   localparam logic [1:0] AFT_DONE   = 2'd2;

   function automatic logic [TIME_BITS-1:0] sat_time(input logic [31:0] v);
      logic [47:0] w;
      w = 48'(v);
      return (w > 48'(TMAX)) ? TMAX : w[TIME_BITS-1:0];
   endfunction

   function automatic logic [CW-1:0] popcount(input logic [MAX_SLOTS-1:0] v);
      logic [CW-1:0] n;
      n = '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         n = n + CW'(v[i]);
      end
      return n;
   endfunction

   logic [3:0]  state_ff, state_in;
   logic [1:0]  after_ff, after_in;
   logic [1:0]  status_ff, status_in;
   logic [31:0] seq_ff, seq_in;
   logic [31:0] hold_seq_ff, hold_seq_in;
   logic [WW-1:0] walk_ff, walk_in;
   logic [CW-1:0] count_ff, count_in;
   logic [TIW-1:0] clr_ff, clr_in;

   logic [2:0]  act_ff;
   logic [7:0]  tgt_ff, key_ff;
   logic [31:0] interval_ff, delay_ff, dt_ff;
   logic signed [16:0] rep_ff;
   logic signed [15:0] pri_ff;
   logic        run_ff, pause_ff;

   logic [1:0]  flag_mem [TARGET_COUNT];
   logic [1:0]  rdata_ff;
   logic        mem_we;
   logic [TIW-1:0] mem_waddr;
   logic [1:0]  mem_wdata;
   logic [11:0] tidx_full;
   logic [TIW-1:0] tidx;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [7:0]  rsp_target_ff, rsp_target_in;
   logic [7:0]  rsp_key_ff, rsp_key_in;
   logic [31:0] rsp_dt_ff, rsp_dt_in;
   logic [4:0]  rsp_count_ff, rsp_count_in;
   logic        rsp_last_ff, rsp_last_in;

   kptt_pkg::cell_ctl_type    ctl;
   logic [TIME_BITS-1:0]      dt_t;
   kptt_pkg::slot_info_type   new_info;
   logic [2:0][TIME_BITS-1:0] new_time;
   kptt_pkg::slot_info_type   info_q    [MAX_SLOTS];
   logic [2:0][TIME_BITS-1:0] time_q    [MAX_SLOTS];
   kptt_pkg::slot_info_type   prev_info [MAX_SLOTS];
   logic [2:0][TIME_BITS-1:0] prev_time [MAX_SLOTS];
   kptt_pkg::slot_info_type   next_info [MAX_SLOTS];
   logic [2:0][TIME_BITS-1:0] next_time [MAX_SLOTS];
   logic [MAX_SLOTS:0]        hole, ins;
   logic [MAX_SLOTS-1:0]      need, match, fire, rm, valid;
   logic [31:0]               match_seq;

   assign tidx_full = kptt_pkg::kptt_mod(tgt_ff, TARGET_COUNT);
   assign tidx      = tidx_full[TIW-1:0];
   assign dt_t      = sat_time(dt_ff);
   assign busy      = state_ff != ST_IDLE;

   always_comb begin
      new_info            = '0;
      new_info.valid      = 1'b1;
      new_info.target     = tgt_ff;
      new_info.key        = key_ff;
      new_info.rpt        = (rep_ff < kptt_pkg::REPEAT_FOREVER) ? kptt_pkg::REPEAT_FOREVER
                                                                 : rep_ff;
      new_info.prio       = pri_ff;
      new_info.seq_num    = hold_seq_ff;
      new_info.fire_count = '0;
      new_info.run        = rdata_ff[1];
      new_info.pause      = rdata_ff[0];
      new_time                        = '0;
      new_time[kptt_pkg::TM_INTERVAL] = sat_time(interval_ff);
      new_time[kptt_pkg::TM_DELAY]    = sat_time(delay_ff);
   end

   assign hole[0] = 1'b0;
   assign ins[0]  = 1'b0;

   for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign prev_info[i] = new_info;
         assign prev_time[i] = new_time;
      end else begin : g_mid
         assign prev_info[i] = info_q[i-1];
         assign prev_time[i] = time_q[i-1];
      end
      if (i == MAX_SLOTS - 1) begin : g_last
         assign next_info[i] = '0;
         assign next_time[i] = '0;
      end else begin : g_body
         assign next_info[i] = info_q[i+1];
         assign next_time[i] = time_q[i+1];
      end
      assign valid[i] = info_q[i].valid;

      kptt_cell #(
         .TARGET_COUNT(TARGET_COUNT),
         .TIME_BITS   (TIME_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .dt       (dt_t),
         .new_info (new_info),
         .new_time (new_time),
         .prev_info(prev_info[i]),
         .prev_time(prev_time[i]),
         .next_info(next_info[i]),
         .next_time(next_time[i]),
         .hole_in  (hole[i]),
         .ins_in   (ins[i]),
         .info_q   (info_q[i]),
         .time_q   (time_q[i]),
         .hole_out (hole[i+1]),
         .ins_out  (ins[i+1]),
         .need     (need[i]),
         .match    (match[i]),
         .fire     (fire[i]),
         .rm       (rm[i])
      );
   end

   // keys are unique, so at most one cell matches
   always_comb begin
      match_seq = '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         match_seq = match_seq | (match[i] ? info_q[i].seq_num : 32'd0);
      end
   end

   always_comb begin
      state_in    = state_ff;
      after_in    = after_ff;
      status_in   = status_ff;
      seq_in      = seq_ff;
      hold_seq_in = hold_seq_ff;
      walk_in     = walk_ff;
      count_in    = count_ff;
      clr_in      = clr_ff;
      ctl         = '0;
      ctl.op      = kptt_pkg::OP_HOLD;
      ctl.target  = tgt_ff;
      ctl.key     = key_ff;
      ctl.run     = run_ff;
      ctl.pause   = pause_ff;
      mem_we      = 1'b0;
      mem_waddr   = tidx;
      mem_wdata   = {run_ff, pause_ff};
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = kptt_pkg::KIND_ACK;
      rsp_status_in = kptt_pkg::STATUS_OK;
      rsp_target_in = '0;
      rsp_key_in    = '0;
      rsp_dt_in     = '0;
      rsp_count_in  = 5'(count_ff);
      rsp_last_in   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_CMD;
            end
         end
         ST_CLR: begin
            // flags come up running and not paused
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = 2'b10;
            clr_in    = clr_ff + TIW'(1);
            if (clr_ff == TIW'(TARGET_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_CMD: begin
            status_in = kptt_pkg::STATUS_OK;
            after_in  = AFT_ACK;
            state_in  = ST_ACK;
            case (act_ff)
               kptt_pkg::ACT_SCHEDULE: begin
                  if (tgt_ff == '0 || key_ff == '0) begin
                     status_in = kptt_pkg::STATUS_IGNORED;
                  end else if (|match) begin
                     ctl.op      = kptt_pkg::OP_DROP_KEY;
                     hold_seq_in = match_seq;
                     after_in    = AFT_INSERT;
                     state_in    = ST_COMPACT;
                  end else if (valid[MAX_SLOTS-1]) begin
                     status_in = kptt_pkg::STATUS_FULL;
                  end else begin
                     hold_seq_in = seq_ff;
                     seq_in      = seq_ff + 32'd1;
                     after_in    = AFT_INSERT;
                     state_in    = ST_COMPACT;
                  end
               end
               kptt_pkg::ACT_UNSCHED_KEY: begin
                  if (tgt_ff == '0 || key_ff == '0) begin
                     status_in = kptt_pkg::STATUS_IGNORED;
                  end else begin
                     ctl.op   = kptt_pkg::OP_DROP_KEY;
                     state_in = ST_COMPACT;
                  end
               end
               kptt_pkg::ACT_UNSCHED_TARGET: begin
                  if (tgt_ff == '0) begin
                     status_in = kptt_pkg::STATUS_IGNORED;
                  end else begin
                     ctl.op   = kptt_pkg::OP_DROP_TARGET;
                     state_in = ST_COMPACT;
                  end
               end
               kptt_pkg::ACT_TICK: begin
                  ctl.op   = kptt_pkg::OP_EVAL;
                  state_in = ST_CNT;
               end
               kptt_pkg::ACT_SET_STATE: begin
                  if (tgt_ff == '0) begin
                     status_in = kptt_pkg::STATUS_IGNORED;
                  end else begin
                     ctl.op = kptt_pkg::OP_FLAGS;
                     mem_we = 1'b1;
                  end
               end
               default: begin
                  status_in = kptt_pkg::STATUS_IGNORED;
               end
            endcase
         end
         ST_COMPACT: begin
            if (|need) begin
               ctl.op = kptt_pkg::OP_COMPACT;
            end else begin
               case (after_ff)
                  AFT_INSERT: state_in = ST_INSERT;
                  AFT_DONE:   state_in = ST_DONE;
                  default:    state_in = ST_ACK;
               endcase
            end
         end
         ST_INSERT: begin
            ctl.op   = kptt_pkg::OP_INSERT;
            state_in = ST_ACK;
         end
         ST_ACK: begin
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = kptt_pkg::KIND_ACK;
            rsp_status_in = status_ff;
            rsp_count_in  = 5'(popcount(valid));
            rsp_last_in   = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_CNT: begin
            count_in = popcount(valid & ~rm);
            walk_in  = '0;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (fire[walk_ff]) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = kptt_pkg::KIND_FIRE;
               rsp_target_in = info_q[walk_ff].target;
               rsp_key_in    = info_q[walk_ff].key;
               rsp_dt_in     = 32'(dt_t);
            end
            walk_in = walk_ff + WW'(1);
            if (walk_ff == WW'(MAX_SLOTS - 1)) begin
               state_in = ST_CLEAN;
            end
         end
         ST_CLEAN: begin
            ctl.op   = kptt_pkg::OP_CLEAN;
            after_in = AFT_DONE;
            state_in = ST_COMPACT;
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = kptt_pkg::KIND_DONE;
            rsp_last_in  = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         flag_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= flag_mem[tidx];
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         act_ff      <= req_action;
         tgt_ff      <= req_target_id;
         key_ff      <= req_key_id;
         interval_ff <= req_interval;
         delay_ff    <= req_delay;
         rep_ff      <= req_repeat_req;
         pri_ff      <= req_priority_req;
         dt_ff       <= req_dt;
         run_ff      <= req_running;
         pause_ff    <= req_paused;
      end
      after_ff      <= after_in;
      status_ff     <= status_in;
      hold_seq_ff   <= hold_seq_in;
      walk_ff       <= walk_in;
      count_ff      <= count_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_target_ff <= rsp_target_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_dt_ff     <= rsp_dt_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_CLR;
         clr_ff       <= '0;
         seq_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_kind_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_fired_target    = rsp_target_ff;
   assign rsp_fired_key       = rsp_key_ff;
   assign rsp_fired_dt        = rsp_dt_ff;
   assign rsp_scheduled_count = rsp_count_ff;
   assign rsp_last            = rsp_last_ff;

   `KPTT_ASSERT_IMPL(a_last_frees_block, rsp_valid_ff && rsp_last_ff, state_ff == ST_IDLE,
      "final word shown while the block is still busy")
   `KPTT_ASSERT_IMPL(a_row_packed_when_idle, state_ff == ST_IDLE, !(|need),
      "live slots not packed at the front of the row while idle")
   `KPTT_ASSERT_NEXT(a_fire_reaches_port, state_ff == ST_WALK && fire[walk_ff],
      rsp_valid_ff && rsp_kind_ff == kptt_pkg::KIND_FIRE,
      "firing slot did not produce a fire word")

endmodule

// ===== bench/keyed_periodic_timer_table_top_tb.sv =====
`timescale 1ns / 1ps
module keyed_periodic_timer_table_top_tb;

   localparam int SLOTS = 16;
   localparam int RANDOM_WORDS = 300;

   typedef struct {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [7:0]  tgt;
      logic [7:0]  key;
      logic [31:0] dt;
      logic [4:0]  count;
      logic        last;
   } timer_event_type;

   typedef struct {
      logic [2:0]         action;
      logic [7:0]         tgt;
      logic [7:0]         key;
      logic [31:0]        interval;
      logic [31:0]        delay;
      logic signed [16:0] rpt;
      logic signed [15:0] prio;
      logic [31:0]        dt;
      logic               run;
      logic               pause;
      logic               typed;
      logic [1:0]         status;
      logic [4:0]         count;
   } timer_cmd_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [2:0]  req_action = '0;
   logic [7:0]  req_target_id = '0;
   logic [7:0]  req_key_id = '0;
   logic [31:0] req_interval = '0;
   logic [31:0] req_delay = '0;
   logic signed [16:0] req_repeat_req = '0;
   logic signed [15:0] req_priority_req = '0;
   logic [31:0] req_dt = '0;
   logic req_running = 0;
   logic req_paused = 0;
   logic rsp_valid;
   logic [1:0]  rsp_kind;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_fired_target;
   logic [7:0]  rsp_fired_key;
   logic [31:0] rsp_fired_dt;
   logic [4:0]  rsp_scheduled_count;
   logic        rsp_last;

   // typed expectation for the word currently on the request ports
   logic       cur_typed = 0;
   logic [1:0] cur_status = '0;
   logic [4:0] cur_count = '0;

   keyed_periodic_timer_table_top DUT (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // timer table mirror
   logic               tt_valid [SLOTS];
   logic [7:0]         tt_target [SLOTS];
   logic [7:0]         tt_key [SLOTS];
   logic [31:0]        tt_interval [SLOTS];
   logic [31:0]        tt_delay [SLOTS];
   logic [31:0]        tt_elapsed [SLOTS];
   logic signed [16:0] tt_rpt [SLOTS];
   logic signed [15:0] tt_prio [SLOTS];
   logic [31:0]        tt_seq [SLOTS];
   logic [16:0]        tt_fires [SLOTS];
   logic [31:0]        tt_next_seq = 0;
   logic               tgt_running [256];
   logic               tgt_paused [256];

   timer_event_type pending_events[$];
   bit failed = 0;

   initial begin
      for (int i = 0; i < SLOTS; i++) tt_valid[i] = 0;
      for (int i = 0; i < 256; i++) begin
         tgt_running[i] = 1;
         tgt_paused[i] = 0;
      end
   end

   function automatic bit fires_first(int a, int b);
      if (tt_prio[a] != tt_prio[b]) return tt_prio[a] < tt_prio[b];
      if (tt_seq[a] != tt_seq[b]) return tt_seq[a] < tt_seq[b];
      return a < b;
   endfunction

   function automatic logic [1:0] schedule_slot(timer_cmd_type c);
      int s;
      int free_slot;
      logic signed [16:0] r;
      s = -1;
      free_slot = -1;
      if (c.tgt == 0 || c.key == 0) return kptt_pkg::STATUS_IGNORED;
      r = (c.rpt < -1) ? -17'sd1 : c.rpt;
      for (int i = 0; i < SLOTS; i++) begin
         if (tt_valid[i] && tt_target[i] == c.tgt && tt_key[i] == c.key) begin
            s = i;
            break;
         end
         if (!tt_valid[i] && free_slot < 0) free_slot = i;
      end
      if (s < 0) begin
         if (free_slot < 0) return kptt_pkg::STATUS_FULL;
         s = free_slot;
         tt_valid[s] = 1;
         tt_target[s] = c.tgt;
         tt_key[s] = c.key;
         tt_seq[s] = tt_next_seq;
         tt_next_seq = tt_next_seq + 1;
      end
      tt_interval[s] = c.interval;
      tt_delay[s] = c.delay;
      tt_elapsed[s] = 0;
      tt_rpt[s] = r;
      tt_prio[s] = c.prio;
      tt_fires[s] = 0;
      return kptt_pkg::STATUS_OK;
   endfunction

   task automatic predict_word(timer_cmd_type c);
      timer_event_type ev[$];
      timer_event_type e;
      timer_event_type f;
      bit walked [SLOTS];
      bit drop [SLOTS];
      logic [1:0] st;
      logic [32:0] sum;
      bit fire;
      int s;
      int live;
      st = kptt_pkg::STATUS_OK;
      e = '{kptt_pkg::KIND_ACK, kptt_pkg::STATUS_OK, 8'd0, 8'd0, 32'd0, 5'd0, 1'b1};
      if (c.action == kptt_pkg::ACT_TICK) begin
         for (int i = 0; i < SLOTS; i++) begin
            walked[i] = !tt_valid[i];
            drop[i] = 0;
         end
         while (1) begin
            s = -1;
            for (int i = 0; i < SLOTS; i++)
               if (!walked[i] && (s < 0 || fires_first(i, s))) s = i;
            if (s < 0) break;
            walked[s] = 1;
            if (!tgt_running[tt_target[s]] || tgt_paused[tt_target[s]]) continue;
            fire = 0;
            if (tt_delay[s] > 0) begin
               if (c.dt >= tt_delay[s]) begin
                  tt_delay[s] = 0;
                  tt_elapsed[s] = 0;
                  fire = 1;
               end else begin
                  tt_delay[s] = tt_delay[s] - c.dt;
               end
            end else if (tt_interval[s] == 0) begin
               fire = 1;
            end else begin
               sum = {1'b0, tt_elapsed[s]} + {1'b0, c.dt};
               tt_elapsed[s] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
               if (tt_elapsed[s] >= tt_interval[s]) begin
                  tt_elapsed[s] = tt_elapsed[s] - tt_interval[s];
                  fire = 1;
               end
            end
            if (!fire) continue;
            f = '{kptt_pkg::KIND_FIRE, kptt_pkg::STATUS_OK, tt_target[s], tt_key[s], c.dt,
                  5'd0, 1'b0};
            ev.insert(ev.size(), f);
            if (tt_fires[s] != kptt_pkg::FIRE_COUNT_MAX) tt_fires[s] = tt_fires[s] + 1;
            if (tt_rpt[s] != kptt_pkg::REPEAT_FOREVER && int'(tt_fires[s]) > int'(tt_rpt[s]))
               drop[s] = 1;
         end
         for (int i = 0; i < SLOTS; i++)
            if (tt_valid[i] && (drop[i] || !tgt_running[tt_target[i]])) tt_valid[i] = 0;
         e.kind = kptt_pkg::KIND_DONE;
      end else begin
         case (c.action)
            kptt_pkg::ACT_SCHEDULE: st = schedule_slot(c);
            kptt_pkg::ACT_UNSCHED_KEY: begin
               if (c.tgt == 0 || c.key == 0) st = kptt_pkg::STATUS_IGNORED;
               else
                  for (int i = 0; i < SLOTS; i++)
                     if (tt_valid[i] && tt_target[i] == c.tgt && tt_key[i] == c.key)
                        tt_valid[i] = 0;
            end
            kptt_pkg::ACT_UNSCHED_TARGET: begin
               if (c.tgt == 0) st = kptt_pkg::STATUS_IGNORED;
               else
                  for (int i = 0; i < SLOTS; i++)
                     if (tt_valid[i] && tt_target[i] == c.tgt) tt_valid[i] = 0;
            end
            kptt_pkg::ACT_SET_STATE: begin
               if (c.tgt == 0) st = kptt_pkg::STATUS_IGNORED;
               else begin
                  tgt_running[c.tgt] = c.run;
                  tgt_paused[c.tgt] = c.pause;
               end
            end
            default: st = kptt_pkg::STATUS_IGNORED;
         endcase
      end
      e.status = st;
      ev.insert(ev.size(), e);
      live = 0;
      for (int i = 0; i < SLOTS; i++) live += tt_valid[i];
      foreach (ev[k]) begin
         ev[k].count = 5'(live);
         pending_events.insert(pending_events.size(), ev[k]);
      end
      // typed directed rows carry the ack status and count read off by hand
      if (c.typed) begin
         pending_events[$].status = c.status;
         pending_events[$].count = c.count;
      end
   endtask

   always @(posedge clock) begin
      timer_cmd_type c;
      timer_event_type x;
      if (!reset && start && !busy) begin
         c = '{req_action, req_target_id, req_key_id, req_interval, req_delay,
               req_repeat_req, req_priority_req, req_dt, req_running, req_paused,
               cur_typed, cur_status, cur_count};
         predict_word(c);
      end
      if (!reset && rsp_valid) begin
         if (pending_events.size() == 0) begin
            $display("%0t: unexpected word kind=%0d status=%0d", $time, rsp_kind, rsp_status);
            failed = 1;
         end else begin
            x = pending_events.pop_front();
            if (rsp_kind !== x.kind || rsp_status !== x.status
                || rsp_fired_target !== x.tgt || rsp_fired_key !== x.key
                || rsp_fired_dt !== x.dt || rsp_scheduled_count !== x.count
                || rsp_last !== x.last) begin
               $display("%0t: expected kind=%0d st=%0d tgt=%0d key=%0d dt=%0h cnt=%0d last=%0d",
                        $time, x.kind, x.status, x.tgt, x.key, x.dt, x.count, x.last);
               $display("%0t:   actual kind=%0d st=%0d tgt=%0d key=%0d dt=%0h cnt=%0d last=%0d",
                        $time, rsp_kind, rsp_status, rsp_fired_target, rsp_fired_key,
                        rsp_fired_dt, rsp_scheduled_count, rsp_last);
               failed = 1;
            end
         end
      end
   end

   task automatic send_word(timer_cmd_type c);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         start = 0;
         repeat (gap) @(negedge clock);
      end
      req_action = c.action;
      req_target_id = c.tgt;
      req_key_id = c.key;
      req_interval = c.interval;
      req_delay = c.delay;
      req_repeat_req = c.rpt;
      req_priority_req = c.prio;
      req_dt = c.dt;
      req_running = c.run;
      req_paused = c.pause;
      cur_typed = c.typed;
      cur_status = c.status;
      cur_count = c.count;
      start = 1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   function automatic timer_cmd_type random_word();
      timer_cmd_type c;
      int pick;
      bit wide;
      pick = $urandom_range(0, 99);
      wide = ($urandom_range(0, 9) == 0);
      c.typed = 0;
      c.status = '0;
      c.count = '0;
      c.action = pick < 35 ? kptt_pkg::ACT_SCHEDULE :
                 pick < 65 ? kptt_pkg::ACT_TICK :
                 pick < 75 ? kptt_pkg::ACT_UNSCHED_KEY :
                 pick < 80 ? kptt_pkg::ACT_UNSCHED_TARGET :
                 pick < 90 ? kptt_pkg::ACT_SET_STATE : 3'($urandom);
      c.tgt = wide ? 8'($urandom) : 8'($urandom_range(1, 5));
      c.key = wide ? 8'($urandom) : 8'($urandom_range(1, 5));
      c.interval = wide ? $urandom : $urandom_range(0, 20);
      c.delay = wide ? $urandom : ($urandom_range(0, 1) ? 32'd0 : $urandom_range(1, 20));
      c.rpt = wide ? 17'($urandom) : 17'(int'($urandom_range(0, 6)) - 1);
      c.prio = wide ? 16'($urandom) : 16'(int'($urandom_range(0, 6)) - 3);
      c.dt = wide ? $urandom : $urandom_range(0, 15);
      c.run = ($urandom_range(0, 4) != 0);
      c.pause = ($urandom_range(0, 3) == 0);
      return c;
   endfunction

   timer_cmd_type directed_rows[] = '{
      '{kptt_pkg::ACT_TICK, 8'd0, 8'd0, 32'd0, 32'd0, 17'sd0, 16'sd0, 32'd5, 1'b0, 1'b0,
        1'b0, kptt_pkg::STATUS_OK, 5'd0},
      '{kptt_pkg::ACT_SCHEDULE, 8'd0, 8'd3, 32'd1, 32'd0, 17'sd0, 16'sd0, 32'd0, 1'b0, 1'b0,
        1'b1, kptt_pkg::STATUS_IGNORED, 5'd0},
      '{kptt_pkg::ACT_SCHEDULE, 8'd3, 8'd0, 32'd1, 32'd0, 17'sd0, 16'sd0, 32'd0, 1'b0, 1'b0,
        1'b1, kptt_pkg::STATUS_IGNORED, 5'd0},
      '{kptt_pkg::ACT_UNSCHED_KEY, 8'd0, 8'd1, 32'd0, 32'd0, 17'sd0, 16'sd0, 32'd0, 1'b0,
        1'b0, 1'b1, kptt_pkg::STATUS_IGNORED, 5'd0},
      '{kptt_pkg::ACT_UNSCHED_TARGET, 8'd0, 8'd1, 32'd0, 32'd0, 17'sd0, 16'sd0, 32'd0, 1'b0,
        1'b0, 1'b1, kptt_pkg::STATUS_IGNORED, 5'd0},
      '{kptt_pkg::ACT_SET_STATE, 8'd0, 8'd0, 32'd0, 32'd0, 17'sd0, 16'sd0, 32'd0, 1'b0, 1'b1,
        1'b1, kptt_pkg::STATUS_IGNORED, 5'd0},
      '{3'd5, 8'd1, 8'd1, 32'd0, 32'd0, 17'sd0, 16'sd0, 32'd0, 1'b0, 1'b0,
        1'b1, kptt_pkg::STATUS_IGNORED, 5'd0},
      '{3'd7, 8'd1, 8'd1, 32'd0, 32'd0, 17'sd0, 16'sd0, 32'd0, 1'b1, 1'b1,
        1'b1, kptt_pkg::STATUS_IGNORED, 5'd0},
      '{kptt_pkg::ACT_UNSCHED_KEY, 8'd4, 8'd4, 32'd0, 32'd0, 17'sd0, 16'sd0, 32'd0, 1'b0,
        1'b0, 1'b1, kptt_pkg::STATUS_OK, 5'd0},
      '{kptt_pkg::ACT_SCHEDULE, 8'd255, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'sd65535,
        16'sh8000, 32'd0, 1'b0, 1'b0, 1'b1, kptt_pkg::STATUS_OK, 5'd1},
      '{kptt_pkg::ACT_SCHEDULE, 8'd1, 8'd1, 32'd0, 32'd0, -17'sd1, 16'sd32767, 32'd0, 1'b0,
        1'b0, 1'b1, kptt_pkg::STATUS_OK, 5'd2},
      // repeat below forever clamps to forever
      '{kptt_pkg::ACT_SCHEDULE, 8'd1, 8'd2, 32'd3, 32'd2, 17'sh10000, 16'sd0, 32'd0, 1'b0,
        1'b0, 1'b1, kptt_pkg::STATUS_OK, 5'd3},
      '{kptt_pkg::ACT_SCHEDULE, 8'd2, 8'd1, 32'd5, 32'd0, 17'sd1, 16'sd0, 32'd0, 1'b0, 1'b0,
        1'b1, kptt_pkg::STATUS_OK, 5'd4},
      '{kptt_pkg::ACT_TICK, 8'd0, 8'd0, 32'd0, 32'd0, 17'sd0, 16'sd0, 32'd0, 1'b0, 1'b0,
        1'b0, kptt_pkg::STATUS_OK, 5'd0},
      '{kptt_pkg::ACT_TICK, 8'd0, 8'd0, 32'd0, 32'd0, 17'sd0, 16'sd0, 32'd2, 1'b0, 1'b0,
        1'b0, kptt_pkg::STATUS_OK, 5'd0},
      '{kptt_pkg::ACT_TICK, 8'd0, 8'd0, 32'd0, 32'd0, 17'sd0, 16'sd0, 32'hFFFF_FFFF, 1'b0,
        1'b0, 1'b0, kptt_pkg::STATUS_OK, 5'd0},
      '{kptt_pkg::ACT_SCHEDULE, 8'd1, 8'd1, 32'd7, 32'd1, 17'sd2, 16'sd5, 32'd0, 1'b0, 1'b0,
        1'b0, kptt_pkg::STATUS_OK, 5'd0},
      '{kptt_pkg::ACT_SET_STATE, 8'd2, 8'd0, 32'd0, 32'd0, 17'sd0, 16'sd0, 32'd0, 1'b1, 1'b1,
        1'b0, kptt_pkg::STATUS_OK, 5'd0},
      '{kptt_pkg::ACT_SET_STATE, 8'd255, 8'd0, 32'd0, 32'd0, 17'sd0, 16'sd0, 32'd0, 1'b0,
        1'b0, 1'b0, kptt_pkg::STATUS_OK, 5'd0},
      '{kptt_pkg::ACT_TICK, 8'd0, 8'd0, 32'd0, 32'd0, 17'sd0, 16'sd0, 32'd9, 1'b0, 1'b0,
        1'b0, kptt_pkg::STATUS_OK, 5'd0},
      '{kptt_pkg::ACT_UNSCHED_TARGET, 8'd1, 8'd0, 32'd0, 32'd0, 17'sd0, 16'sd0, 32'd0, 1'b0,
        1'b0, 1'b0, kptt_pkg::STATUS_OK, 5'd0}
   };

   initial begin
      timer_cmd_type c;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;
      foreach (directed_rows[i]) send_word(directed_rows[i]);
      // fill the table past capacity, then fire everything at once
      for (int k = 1; k <= 17; k++) begin
         c = random_word();
         c.action = kptt_pkg::ACT_SCHEDULE;
         c.tgt = 8'd9;
         c.key = 8'(k);
         c.typed = 0;
         c.delay = 0;
         c.interval = 0;
         send_word(c);
      end
      c.action = kptt_pkg::ACT_TICK;
      send_word(c);
      c.action = kptt_pkg::ACT_SET_STATE;
      c.run = 1;
      c.pause = 0;
      send_word(c);
      c.action = kptt_pkg::ACT_UNSCHED_TARGET;
      send_word(c);
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         // stretches without request gaps
         if (n % 60 < 15) begin
            c = random_word();
            start = 1;
            req_action = c.action;
            req_target_id = c.tgt;
            req_key_id = c.key;
            req_interval = c.interval;
            req_delay = c.delay;
            req_repeat_req = c.rpt;
            req_priority_req = c.prio;
            req_dt = c.dt;
            req_running = c.run;
            req_paused = c.pause;
            cur_typed = 0;
            do @(posedge clock); while (busy);
            @(negedge clock);
         end else begin
            send_word(random_word());
         end
      end
      start = 0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (!failed && pending_events.size() == 0)
         $display("** keyed_periodic_timer_table_top: PASSED **");
      else
         $display("** keyed_periodic_timer_table_top: FAILED **");
      $finish;
   end

   initial begin
      #400000;
      $display("** keyed_periodic_timer_table_top: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/kptt_pkg.sv
sv/kptt_cell.sv
sv/keyed_periodic_timer_table_top.sv
bench/keyed_periodic_timer_table_top_tb.sv
